/* rtl/dq_pkg.sv */
// shared types, sizes and codes for the double-ended queue
`default_nettype none
package dq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 64;
  localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_NONE       = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;
  localparam logic [2:0] OP_REVERSE    = 3'd5;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
  localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic [63:0] front_word;
    logic [63:0] back_word;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [1:0]  error_code;
  } dq_out_t;

  // access request from the controller to the word store
  typedef struct packed {
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [IDX_BITS-1:0]  rd_addr_a;
    logic [IDX_BITS-1:0]  rd_addr_b;
  } dq_mem_req_t;

  // state of the queue as seen by the result path
  typedef struct packed {
    logic                show;
    logic                reversed;
    logic [CNT_BITS-1:0] count;
    logic [1:0]          err;
  } dq_status_t;

endpackage
`default_nettype wire

/* rtl/double_ended_queue.sv */
// top level of the bounded double-ended queue of words
//
// usage
//   - an item (opcode, push_value) is taken at a rising edge with start high
//     and busy low; opcodes: none, push front, push back, pop front,
//     pop back, reverse (codes 6 and 7 do nothing)
//   - each item gives exactly one result on result, marked by done for one
//     cycle: front and back words, count, empty flag and error code, all
//     describing the queue after the item
//   - after the accepting edge come the read state and then the show state,
//     in which done is high; busy stays high until done has gone by
//   - this order comes from the word store: the update is written in the
//     accept cycle, both ends are read in the next cycle, and the store's
//     read data is registered before it reaches the result
//   - a push when full reports push-full and drops the word, a pop when
//     empty reports pop-empty; neither changes the queue
//   - reverse only flips the direction flag, swapping logical front and back
//   - reset (rst, synchronous) empties the queue and clears the flag; store
//     contents are left as they are, only held entries are ever shown
//   - the receiver has no way to stall: a result is there for one cycle only
`default_nettype none
module double_ended_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire dq_pkg::dq_in_t  cmd,
  output logic                 busy,
  output logic                 done,
  output dq_pkg::dq_out_t      result
);
  import dq_pkg::*;

  dq_mem_req_t          mem_req;
  dq_status_t           status;
  logic [WORD_BITS-1:0] rd_data_a, rd_data_b;
  logic [WORD_BITS-1:0] front_phys, back_phys;
  logic [31:0]          count_ext;
  logic                 empty;

  // sequencer with head, count and direction registers
  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .mem_req (mem_req),
    .status  (status)
  );

  // ring store of words
  dq_store u_store (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign empty     = (status.count == '0);
  assign count_ext = 32'(status.count);

  // an empty queue shows zero at both ends
  assign front_phys = empty ? '0 : rd_data_a;
  assign back_phys  = empty ? '0 : rd_data_b;

  assign done = status.show;

  // physical ends swap roles when reversed
  assign result.front_word  = 64'(status.reversed ? back_phys : front_phys);
  assign result.back_word   = 64'(status.reversed ? front_phys : back_phys);
  assign result.entry_count = count_ext[4:0];
  assign result.is_empty    = empty;
  assign result.error_code  = status.err;

endmodule
`default_nettype wire

/* rtl/dq_store.sv */
// word store: one write port, two registered read ports
`default_nettype none
module dq_store (
  input  wire logic                         clk,
  input  wire dq_pkg::dq_mem_req_t          req,
  output logic [dq_pkg::WORD_BITS-1:0]      rd_data_a,
  output logic [dq_pkg::WORD_BITS-1:0]      rd_data_b
);
  import dq_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_a <= mem[req.rd_addr_a];
      rd_data_b <= mem[req.rd_addr_b];
    end
  end

endmodule
`default_nettype wire

/* rtl/dq_ctrl.sv */
// pointer, count and direction control with the item sequencer
`default_nettype none
module dq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire dq_pkg::dq_in_t      cmd,
  output logic                     busy,
  output dq_pkg::dq_mem_req_t      mem_req,
  output dq_pkg::dq_status_t       status
);
  import dq_pkg::*;

  localparam int SUM_BITS = CNT_BITS + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [1:0]          state, state_next;
  logic [IDX_BITS-1:0] head, head_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic                reversed, reversed_next;
  logic [1:0]          err, err_next;

  logic                accept;
  logic                full, empty;
  logic                at_front_push, at_front_pop;
  logic [IDX_BITS-1:0] head_dec, head_inc, tail_free, tail_used;
  logic [CNT_BITS-1:0] last_ofs;

  // (base + offset) mod DEPTH, offset below DEPTH + 1
  function automatic logic [IDX_BITS-1:0] ring_add(logic [IDX_BITS-1:0] base,
                                                   logic [CNT_BITS-1:0] ofs);
    logic [SUM_BITS-1:0] sum;
    sum = SUM_BITS'(base) + SUM_BITS'(ofs);
    if (sum >= SUM_BITS'(DEPTH)) begin
      sum = sum - SUM_BITS'(DEPTH);
    end
    return IDX_BITS'(sum);
  endfunction

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign full   = (count == CNT_BITS'(DEPTH));
  assign empty  = (count == '0);

  assign at_front_push = (cmd.opcode == OP_PUSH_FRONT) != reversed;
  assign at_front_pop  = (cmd.opcode == OP_POP_FRONT) != reversed;

  assign head_dec  = (head == '0) ? IDX_BITS'(DEPTH - 1) : head - IDX_BITS'(1);
  assign head_inc  = (head == IDX_BITS'(DEPTH - 1)) ? '0 : head + IDX_BITS'(1);
  assign tail_free = ring_add(head, count);
  assign last_ofs  = empty ? '0 : count - CNT_BITS'(1);
  assign tail_used = ring_add(head, last_ofs);

  always_comb begin
    head_next     = head;
    count_next    = count;
    reversed_next = reversed;
    err_next      = err;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = head_dec;
    mem_req.wr_data = cmd.push_value[WORD_BITS-1:0];
    // ends are read in the cycle after the update has been written
    mem_req.rd_en     = (state == ST_READ);
    mem_req.rd_addr_a = head;
    mem_req.rd_addr_b = tail_used;
    if (accept) begin
      err_next = ERR_OK;
      unique case (cmd.opcode) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            err_next = ERR_PUSH_FULL;
          end else begin
            mem_req.wr_en = 1'b1;
            count_next    = count + CNT_BITS'(1);
            if (at_front_push) begin
              mem_req.wr_addr = head_dec;
              head_next       = head_dec;
            end else begin
              mem_req.wr_addr = tail_free;
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            err_next = ERR_POP_EMPTY;
          end else begin
            count_next = count - CNT_BITS'(1);
            if (at_front_pop) begin
              head_next = head_inc;
            end
          end
        end
        OP_REVERSE: begin
          reversed_next = !reversed;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_READ;
      ST_READ: state_next = ST_SHOW;
      ST_SHOW: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      reversed <= 1'b0;
      err      <= ERR_OK;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      reversed <= reversed_next;
      err      <= err_next;
    end
  end

  assign status.show     = (state == ST_SHOW);
  assign status.reversed = reversed;
  assign status.count    = count;
  assign status.err      = err;

endmodule
`default_nettype wire

/* tb/tb_double_ended_queue.sv */
// self-checking testbench for the bounded double-ended queue of words
`timescale 1ns / 100ps

module tb_double_ended_queue;
  import dq_pkg::*;

  // generous cycle budget for the whole run
  localparam int RUN_LIMIT    = 200000;
  // done trails the accepting edge by the read and show states, which the drain wait covers
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 444;

  // opcode values with no meaning, the block treats them as no operation
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  dq_in_t  cmd   = '0;
  logic    busy;
  logic    done;
  dq_out_t result;

  double_ended_queue u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // items waiting to be offered, and views of the queue still to come back
  dq_in_t  cmd_backlog[$];
  dq_out_t expected_views[$];

  int sender_idle_pct = 0;
  int error_count     = 0;
  int cycle_count     = 0;

  // shadow copy of the queue: ring store, physical head, count, direction
  logic [WORD_BITS-1:0] shadow_words[DEPTH];
  int                   shadow_head     = 0;
  int                   shadow_count    = 0;
  logic                 shadow_reversed = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one item to the shadow queue and return the view the block should show
  function automatic dq_out_t predict_deque_op(input dq_in_t item);
    dq_out_t              view;
    logic [WORD_BITS-1:0] phys_front;
    logic [WORD_BITS-1:0] phys_back;
    logic                 at_phys_front;
    logic [1:0]           err;
    err = ERR_OK;
    case (item.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          // full: word dropped, nothing moves
          err = ERR_PUSH_FULL;
        end else begin
          // a logical front push lands at the physical front unless reversed
          at_phys_front = (item.opcode == OP_PUSH_FRONT) ^ shadow_reversed;
          if (at_phys_front) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_words[shadow_head] = item.push_value[WORD_BITS-1:0];
          end else begin
            shadow_words[(shadow_head + shadow_count) % DEPTH] =
              item.push_value[WORD_BITS-1:0];
          end
          shadow_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) begin
          err = ERR_POP_EMPTY;
        end else begin
          at_phys_front = (item.opcode == OP_POP_FRONT) ^ shadow_reversed;
          if (at_phys_front) begin
            shadow_head = (shadow_head + 1) % DEPTH;
          end
          shadow_count--;
        end
      end
      OP_REVERSE: begin
        // flips even when empty, with no visible effect then
        shadow_reversed = ~shadow_reversed;
      end
      default: begin
      end
    endcase

    // only held entries are looked at, so unwritten slots are never read
    phys_front = '0;
    phys_back  = '0;
    if (shadow_count != 0) begin
      phys_front = shadow_words[shadow_head];
      phys_back  = shadow_words[(shadow_head + shadow_count - 1) % DEPTH];
    end
    view             = '0;
    view.front_word  = shadow_reversed ? phys_back : phys_front;
    view.back_word   = shadow_reversed ? phys_front : phys_back;
    view.entry_count = shadow_count[4:0];
    view.is_empty    = (shadow_count == 0);
    view.error_code  = err;
    return view;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got,
             want);
    error_count++;
  endtask

  task automatic queue_item(input logic [2:0] op, input logic [63:0] value);
    dq_in_t item;
    item.opcode     = op;
    item.push_value = value;
    cmd_backlog.push_back(item);
  endtask

  // random items in runs that lean toward filling, draining or a mix,
  // so the queue swings between empty and full many times
  task automatic queue_random_items(input int n);
    int          run_left;
    int          push_share;
    int          r;
    logic [2:0]  op;
    logic [63:0] value;
    run_left   = 0;
    push_share = 50;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        case ($urandom_range(2))
          0:       push_share = 72;
          1:       push_share = 18;
          default: push_share = 45;
        endcase
        run_left = $urandom_range(40, 8);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < push_share / 2) begin
        op = OP_PUSH_FRONT;
      end else if (r < push_share) begin
        op = OP_PUSH_BACK;
      end else if (r < push_share + (90 - push_share) / 2) begin
        op = OP_POP_FRONT;
      end else if (r < 90) begin
        op = OP_POP_BACK;
      end else if (r < 95) begin
        op = OP_REVERSE;
      end else begin
        // noise over the whole opcode space, spare codes included
        op = 3'($urandom_range(7));
      end
      case ($urandom_range(9))
        0:       value = '1;
        1:       value = '0;
        2:       value = 64'h8000_0000_0000_0001;
        default: value = {$urandom, $urandom};
      endcase
      queue_item(op, value);
    end
  endtask

  // hold off new items until every expected view has come back
  task automatic wait_drained;
    while (cmd_backlog.size() != 0 || start || expected_views.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // driver: an item is taken at an edge with start high and busy low
  always @(posedge clk) begin
    logic accepted;
    accepted = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (accepted) begin
        expected_views.push_back(predict_deque_op(cmd));
      end
      if (start && !accepted) begin
        // keep the offer up until the block takes it
      end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        cmd   <= cmd_backlog.pop_front();
        start <= 1'b1;
      end else begin
        // idle: junk on the payload must be ignored while start is low
        start <= 1'b0;
        cmd   <= {3'($urandom), $urandom, $urandom};
      end
    end
  end

  // monitor: each done pulse carries one view, checked against the oldest
  always @(posedge clk) begin
    dq_out_t want;
    if (!rst && done) begin
      if (expected_views.size() == 0) begin
        $display("unexpected result at cycle %0d: %h", cycle_count, result);
        error_count++;
      end else begin
        want = expected_views.pop_front();
        if (result.front_word !== want.front_word)
          report_mismatch("front_word", result.front_word, want.front_word);
        if (result.back_word !== want.back_word)
          report_mismatch("back_word", result.back_word, want.back_word);
        if (result.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(result.entry_count), 64'(want.entry_count));
        if (result.is_empty !== want.is_empty)
          report_mismatch("is_empty", 64'(result.is_empty), 64'(want.is_empty));
        if (result.error_code !== want.error_code)
          report_mismatch("error_code", 64'(result.error_code), 64'(want.error_code));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_views.size());
      $display("tb_double_ended_queue: FAIL");
      $finish;
    end
  end

  initial begin
    int idle_plan[4];
    // sender idle share per phase; the receiver cannot stall so only the
    // sender side is varied
    idle_plan = '{0, 86, 18, 0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty corner cases, spare codes, fill to full, overflow
    sender_idle_pct = 0;
    queue_item(OP_POP_FRONT, 64'h0);
    queue_item(OP_POP_BACK, '1);
    queue_item(OP_REVERSE, 64'h0);
    queue_item(OP_REVERSE, 64'h0);
    queue_item(OP_SPARE_6, '1);
    queue_item(OP_SPARE_7, '1);
    queue_item(OP_NONE, 64'h5555_5555_5555_5555);
    queue_item(OP_PUSH_FRONT, '1);
    queue_item(OP_PUSH_BACK, 64'h0);
    // fourteen more alternating ends brings the count to the full depth
    for (int i = 0; i < DEPTH - 2; i++) begin
      queue_item(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                 i[1] ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h8000_0000_0000_0000 | 64'(i));
    end
    queue_item(OP_PUSH_FRONT, 64'h1234_5678_9ABC_DEF0);
    queue_item(OP_PUSH_BACK, 64'h0FED_CBA9_8765_4321);
    wait_drained();

    // random phases, each drained before the next one starts
    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      queue_random_items(PHASE_ITEMS);
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_views.size() != 0) begin
      $display("%0d results never arrived", expected_views.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("tb_double_ended_queue: PASS");
    end else begin
      $display("tb_double_ended_queue: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dq_pkg.sv
rtl/dq_store.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
